### rtl/group_reverse_reorder_unit_defines.svh
// Assertion macros shared by the reorder unit.
`ifndef GROUP_REVERSE_REORDER_UNIT_DEFINES_SVH
`define GROUP_REVERSE_REORDER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GRR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/grr_pkg.sv
`timescale 1ns / 1ps

package grr_pkg;

   localparam int MAX_GROUP_DEFAULT  = 16;
   localparam int BANK_COUNT         = 2;
   localparam int VALUE_W            = 32;
   localparam int GROUP_SIZE_W       = 5;
   localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RESET = 5'd2;

   // Group descriptor flags passed from front to back.
   typedef struct packed {
      logic bank;
      logic reverse;
      logic list_end;
   } desc_flags_type;

   // Front status, observed at the top level.
   typedef struct packed {
      logic                  bank;
      logic [BANK_COUNT-1:0] busy;
   } front_stat_type;

   // One result entry.
   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic                      run_last;
      logic                      list_done;
   } rsp_entry_type;

endpackage

### rtl/grr_ram.sv
`timescale 1ns / 1ps

module grr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/grr_desc_fifo.sv
`timescale 1ns / 1ps

module grr_desc_fifo #(
   parameter int WIDTH = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        push,
   input  logic [WIDTH-1:0]                            push_data,
   input  logic                                        pop,
   output logic                                        empty,
   output logic [WIDTH-1:0]                            head_data,
   output logic [$clog2(grr_pkg::BANK_COUNT+1)-1:0]    level
);

   localparam int DEPTH   = grr_pkg::BANK_COUNT;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int LEVEL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   // Depth matches the bank count, so a push never finds the queue full.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign empty     = (level_ff == '0);
   assign head_data = entry_ff[rd_ptr_ff];
   assign level     = level_ff;

endmodule

### rtl/grr_front.sv
`timescale 1ns / 1ps

module grr_front #(
   parameter int MAX_GROUP = grr_pkg::MAX_GROUP_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_push,
   output logic                                        req_full,
   input  logic signed [grr_pkg::VALUE_W-1:0]          req_item_value,
   input  logic                                        req_list_end,
   input  logic                                        csr_write_en,
   input  logic [grr_pkg::GROUP_SIZE_W-1:0]            csr_group_size,
   output logic                                        ram_wr_en,
   output logic [$clog2(MAX_GROUP):0]                  ram_wr_addr,
   output logic [grr_pkg::VALUE_W-1:0]                 ram_wr_data,
   output logic                                        desc_push,
   output grr_pkg::desc_flags_type                     desc_flags,
   output logic [$clog2(MAX_GROUP+1)-1:0]              desc_count,
   input  logic                                        release_en,
   input  logic                                        release_bank,
   output grr_pkg::front_stat_type                     stat
);

   localparam int IDX_W = $clog2(MAX_GROUP);
   localparam int CNT_W = $clog2(MAX_GROUP + 1);

   logic [grr_pkg::GROUP_SIZE_W-1:0] group_size_ff;
   logic [IDX_W-1:0]                 fill_ff, fill_in;
   logic                             bank_ff, bank_in;
   logic [grr_pkg::BANK_COUNT-1:0]   busy_ff, busy_in;
   logic                             accept;
   logic [CNT_W-1:0]                 fill_next;
   logic [CNT_W-1:0]                 group_eff;
   logic                             group_full;
   logic                             close_group;

   // Clamp the group size to 1..MAX_GROUP.
   always_comb begin
      if (group_size_ff == '0) begin
         group_eff = CNT_W'(1);
      end else if (32'(group_size_ff) > 32'(MAX_GROUP)) begin
         group_eff = CNT_W'(MAX_GROUP);
      end else begin
         group_eff = CNT_W'(group_size_ff);
      end
   end

   assign req_full    = busy_ff[bank_ff];
   assign accept      = req_push && !req_full;
   assign fill_next   = CNT_W'(fill_ff) + 1'b1;
   assign group_full  = (fill_next >= group_eff);
   assign close_group = accept && (group_full || req_list_end);

   always_comb begin
      fill_in = fill_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (release_en) begin
         busy_in[release_bank] = 1'b0;
      end
      if (close_group) begin
         fill_in          = '0;
         bank_in          = !bank_ff;
         busy_in[bank_ff] = 1'b1;
      end else if (accept) begin
         fill_in = IDX_W'(fill_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= grr_pkg::GROUP_SIZE_RESET;
         fill_ff       <= '0;
         bank_ff       <= 1'b0;
         busy_ff       <= '0;
      end else begin
         if (csr_write_en) begin
            group_size_ff <= csr_group_size;
         end
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

   assign ram_wr_en   = accept;
   assign ram_wr_addr = {bank_ff, fill_ff};
   assign ram_wr_data = req_item_value;

   assign desc_push           = close_group;
   assign desc_flags.bank     = bank_ff;
   assign desc_flags.reverse  = group_full;
   assign desc_flags.list_end = req_list_end;
   assign desc_count          = fill_next;

   assign stat.bank = bank_ff;
   assign stat.busy = busy_ff;

endmodule

### rtl/grr_back.sv
`timescale 1ns / 1ps

module grr_back #(
   parameter int MAX_GROUP = grr_pkg::MAX_GROUP_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        desc_valid,
   input  grr_pkg::desc_flags_type                     desc_flags,
   input  logic [$clog2(MAX_GROUP+1)-1:0]              desc_count,
   output logic                                        desc_pop,
   output logic                                        ram_rd_en,
   output logic [$clog2(MAX_GROUP):0]                  ram_rd_addr,
   input  logic [grr_pkg::VALUE_W-1:0]                 ram_rd_data,
   output logic                                        release_en,
   output logic                                        release_bank,
   output logic                                        rsp_empty,
   input  logic                                        rsp_pop,
   output grr_pkg::rsp_entry_type                      rsp_entry
);

   localparam int IDX_W = $clog2(MAX_GROUP);
   localparam int CNT_W = $clog2(MAX_GROUP + 1);

   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   infl_ff;
   logic                   meta_last_ff;
   logic                   meta_done_ff;
   logic [1:0]             occ_ff, occ_in;
   grr_pkg::rsp_entry_type q_ff [2];
   grr_pkg::rsp_entry_type q_in [2];
   grr_pkg::rsp_entry_type landed;
   logic                   out_pop;
   logic                   issue;
   logic                   issue_last;
   logic [IDX_W-1:0]       rd_idx;

   assign out_pop = rsp_pop && (occ_ff != '0);

   // Issue a read only if its data is sure to find a free output slot.
   assign issue      = desc_valid &&
                       ((3'(occ_ff) + 3'(infl_ff)) <= (out_pop ? 3'd2 : 3'd1));
   assign issue_last = (CNT_W'(idx_ff) + 1'b1) == desc_count;
   assign rd_idx     = desc_flags.reverse ?
                       IDX_W'(desc_count - 1'b1 - CNT_W'(idx_ff)) : idx_ff;

   assign ram_rd_en    = issue;
   assign ram_rd_addr  = {desc_flags.bank, rd_idx};
   assign desc_pop     = issue && issue_last;
   assign release_en   = issue && issue_last;
   assign release_bank = desc_flags.bank;

   always_comb begin
      idx_in = idx_ff;
      if (issue) begin
         idx_in = issue_last ? '0 : idx_ff + 1'b1;
      end
   end

   assign landed.out_value = ram_rd_data;
   assign landed.run_last  = meta_last_ff;
   assign landed.list_done = meta_done_ff;

   // Drop the head on pop, then append the landed read data.
   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      occ_in  = occ_ff;
      if (out_pop) begin
         q_in[0] = q_ff[1];
         occ_in  = occ_ff - 1'b1;
      end
      if (infl_ff) begin
         q_in[occ_in[0]] = landed;
         occ_in          = occ_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         infl_ff <= 1'b0;
         occ_ff  <= '0;
      end else begin
         idx_ff  <= idx_in;
         infl_ff <= issue;
         occ_ff  <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      meta_last_ff <= issue_last;
      meta_done_ff <= issue_last && desc_flags.list_end;
      q_ff[0]      <= q_in[0];
      q_ff[1]      <= q_in[1];
   end

   assign rsp_empty = (occ_ff == '0);
   assign rsp_entry = q_ff[0];

endmodule

### rtl/group_reverse_reorder_unit.sv
`timescale 1ns / 1ps
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+-------------------------
// request   | req_item_value, req_list_end            | req_push, req_full
// response  | rsp_out_value, rsp_run_last,            | rsp_pop, rsp_empty
//           | rsp_list_done                           |
// config    | csr_group_size                          | csr_write_en
//
// One request is taken per cycle while the front's current bank is free; two
// banks of MAX_GROUP entries in the group RAM let one group fill while the
// previous one drains. A closed group of n requests drains one response per
// cycle while rsp_pop keeps up, the first passing the descriptor queue, the
// RAM read and the output queue. req_full rises when both banks hold undrained
// groups; a stalled rsp_pop backs up the output queue, then the RAM reads.
// Reset is synchronous and clears control state only; no clearing pass runs.

`include "group_reverse_reorder_unit_defines.svh"

module group_reverse_reorder_unit #(
   parameter int MAX_GROUP = grr_pkg::MAX_GROUP_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request side
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [grr_pkg::VALUE_W-1:0]    req_item_value,
   input  logic                                  req_list_end,
   // response side
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [grr_pkg::VALUE_W-1:0]    rsp_out_value,
   output logic                                  rsp_run_last,
   output logic                                  rsp_list_done,
   // configuration
   input  logic                                  csr_write_en,
   input  logic [grr_pkg::GROUP_SIZE_W-1:0]      csr_group_size
);

   localparam int IDX_W     = $clog2(MAX_GROUP);
   localparam int CNT_W     = $clog2(MAX_GROUP + 1);
   localparam int ADDR_W    = IDX_W + 1;
   localparam int RAM_DEPTH = 2 ** ADDR_W;
   localparam int FLAGS_W   = $bits(grr_pkg::desc_flags_type);
   localparam int DESC_W    = FLAGS_W + CNT_W;
   localparam int LEVEL_W   = $clog2(grr_pkg::BANK_COUNT + 1);

   // group RAM ports
   logic                         ram_wr_en;
   logic [ADDR_W-1:0]            ram_wr_addr;
   logic [grr_pkg::VALUE_W-1:0]  ram_wr_data;
   logic                         ram_rd_en;
   logic [ADDR_W-1:0]            ram_rd_addr;
   logic [grr_pkg::VALUE_W-1:0]  ram_rd_data;

   // descriptor path, front to back
   logic                         desc_push;
   grr_pkg::desc_flags_type      push_flags;
   logic [CNT_W-1:0]             push_count;
   logic                         desc_pop;
   logic                         desc_empty;
   logic [DESC_W-1:0]            head_data;
   grr_pkg::desc_flags_type      head_flags;
   logic [CNT_W-1:0]             head_count;
   logic [LEVEL_W-1:0]           desc_level;

   // bank release, back to front
   logic                         release_en;
   logic                         release_bank;

   grr_pkg::front_stat_type      front_stat;
   grr_pkg::rsp_entry_type       rsp_entry;

   // Front: take requests, write them into the open bank, close groups.
   grr_front #(
      .MAX_GROUP (MAX_GROUP)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_item_value (req_item_value),
      .req_list_end   (req_list_end),
      .csr_write_en   (csr_write_en),
      .csr_group_size (csr_group_size),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .desc_push      (desc_push),
      .desc_flags     (push_flags),
      .desc_count     (push_count),
      .release_en     (release_en),
      .release_bank   (release_bank),
      .stat           (front_stat)
   );

   // Group storage, one bank per pending group.
   grr_ram #(
      .WIDTH (grr_pkg::VALUE_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Closed groups wait here until the back end takes them.
   grr_desc_fifo #(
      .WIDTH (DESC_W)
   ) u_desc_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_data ({push_flags, push_count}),
      .pop       (desc_pop),
      .empty     (desc_empty),
      .head_data (head_data),
      .level     (desc_level)
   );

   assign head_flags = head_data[DESC_W-1:CNT_W];
   assign head_count = head_data[CNT_W-1:0];

   // Back: walk each group forward or backward and queue the responses.
   grr_back #(
      .MAX_GROUP (MAX_GROUP)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .desc_valid   (!desc_empty),
      .desc_flags   (head_flags),
      .desc_count   (head_count),
      .desc_pop     (desc_pop),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .release_en   (release_en),
      .release_bank (release_bank),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_entry    (rsp_entry)
   );

   assign rsp_out_value = rsp_entry.out_value;
   assign rsp_run_last  = rsp_entry.run_last;
   assign rsp_list_done = rsp_entry.list_done;

   // Every busy bank has exactly one descriptor waiting or in progress.
   `GRR_ASSERT_IMPLY(a_busy_matches_queue, clock, reset, 1'b1, 32'($countones(front_stat.busy)) == 32'(desc_level), "busy banks and queued groups disagree")

   // End of list always closes the open group and moves to the other bank.
   `GRR_ASSERT_NEXT(a_list_end_closes, clock, reset, req_push && !req_full && req_list_end, front_stat.bank != $past(front_stat.bank), "list end did not close the group")

   // The last response of a list also ends its run.
   `GRR_ASSERT_IMPLY(a_done_is_run_last, clock, reset, !rsp_empty && rsp_list_done, rsp_run_last, "list_done without run_last")

endmodule
